/* rtl/fpa_pkg.sv */
// Shared types, codes and the saturation helper of the fixed-point ALU.
`default_nettype none

package fpa_pkg;

    // Word geometry fixed by the operand and result fields.
    localparam int DATA_W            = 32;
    localparam int FRAC_MAX          = 16;
    localparam int FRAC_BITS_DEFAULT = 8;
    localparam int QUO_MAX_W         = DATA_W + FRAC_MAX;
    localparam int MAG_W             = 2 * DATA_W + 1;

    typedef logic [2:0] fpa_action_t;
    typedef logic [1:0] fpa_status_t;

    // Action codes.
    localparam fpa_action_t ACT_ADD = 3'd0;
    localparam fpa_action_t ACT_SUB = 3'd1;
    localparam fpa_action_t ACT_MUL = 3'd2;
    localparam fpa_action_t ACT_DIV = 3'd3;
    localparam fpa_action_t ACT_MIN = 3'd4;
    localparam fpa_action_t ACT_MAX = 3'd5;

    // Status codes.
    localparam fpa_status_t ST_OK   = 2'd0;
    localparam fpa_status_t ST_OVF  = 2'd1;
    localparam fpa_status_t ST_DIVZ = 2'd2;

    // Largest and smallest representable words.
    localparam logic [DATA_W-1:0] WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Input word.
    typedef struct packed {
        fpa_action_t              action;
        logic signed [DATA_W-1:0] operand_a;
        logic signed [DATA_W-1:0] operand_b;
    } fpa_in_t;

    // Output word.
    typedef struct packed {
        logic signed [DATA_W-1:0] result;
        logic                     a_less;
        logic                     a_equal;
        logic                     a_greater;
        fpa_status_t              status;
    } fpa_out_t;

    // Item state handed from cell to cell. A multiply carries its full
    // product in the remainder and low quotient bits, which it does not
    // otherwise need.
    typedef struct packed {
        fpa_action_t          action;
        logic                 lt;
        logic                 eq;
        logic                 neg;
        logic                 na;
        logic                 ma_zero;
        logic [DATA_W-1:0]    mb;
        logic [DATA_W-1:0]    simple;
        logic                 simple_ovf;
        logic [DATA_W-1:0]    rem;
        logic [QUO_MAX_W-1:0] numq;
    } fpa_work_t;

    typedef struct packed {
        logic [DATA_W-1:0] word;
        logic              ovf;
    } fpa_sat_t;

    // Clamp a magnitude with a sign to a word and apply the sign.
    function automatic fpa_sat_t fpa_saturate(input logic neg, input logic [MAG_W-1:0] mag);
        logic [MAG_W-1:0]  limit;
        logic [DATA_W-1:0] v;
        fpa_sat_t          r;
        limit  = neg ? (MAG_W'(1) << (DATA_W - 1))
                     : ((MAG_W'(1) << (DATA_W - 1)) - MAG_W'(1));
        r.ovf  = mag > limit;
        v      = r.ovf ? limit[DATA_W-1:0] : mag[DATA_W-1:0];
        r.word = neg ? (DATA_W'(0) - v) : v;
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/fpa_front.sv */
// Entry stage: operand decode, compare, add, subtract, minimum, maximum, the product and the dividend.
`default_nettype none

module fpa_front #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              up_valid,
    output logic                   up_ready,
    input  wire fpa_pkg::fpa_in_t  up,
    output logic                   down_valid,
    input  wire logic              down_ready,
    output fpa_pkg::fpa_work_t     down
);

    localparam int DW = fpa_pkg::DATA_W;
    localparam int QW = fpa_pkg::QUO_MAX_W;

    logic               valid_reg;
    fpa_pkg::fpa_work_t work_reg;
    fpa_pkg::fpa_work_t work_next;

    logic [DW-1:0]   a;
    logic [DW-1:0]   b;
    logic [DW-1:0]   ma;
    logic [DW-1:0]   mb;
    logic [2*DW-1:0] prod;
    logic [DW:0]     sum_w;
    logic [DW:0]     dif_w;

    // The stage takes a new word whenever it is empty or its content moves on.
    assign up_ready   = !valid_reg || down_ready;
    assign down_valid = valid_reg;
    assign down       = work_reg;

    // Decode the operands and do the compare, add, subtract, minimum, maximum and product.
    always_comb
    begin
        a     = up.operand_a;
        b     = up.operand_b;
        ma    = a[DW-1] ? (DW'(0) - a) : a;
        mb    = b[DW-1] ? (DW'(0) - b) : b;
        prod  = (2*DW)'(ma) * (2*DW)'(mb);
        sum_w = {a[DW-1], a} + {b[DW-1], b};
        dif_w = {a[DW-1], a} - {b[DW-1], b};

        work_next            = '0;
        work_next.action     = up.action;
        work_next.lt         = $signed(a) < $signed(b);
        work_next.eq         = a == b;
        work_next.na         = a[DW-1];
        work_next.neg        = a[DW-1] ^ b[DW-1];
        work_next.ma_zero    = ma == '0;
        work_next.mb         = mb;

        unique case (up.action)
            fpa_pkg::ACT_ADD:
            begin
                work_next.simple_ovf = sum_w[DW] ^ sum_w[DW-1];
                work_next.simple     = sum_w[DW-1:0];
            end
            fpa_pkg::ACT_SUB:
            begin
                work_next.simple_ovf = dif_w[DW] ^ dif_w[DW-1];
                work_next.simple     = dif_w[DW-1:0];
            end
            fpa_pkg::ACT_MUL:
            begin
                work_next.rem  = prod[2*DW-1:DW];
                work_next.numq = QW'(prod[DW-1:0]);
            end
            fpa_pkg::ACT_DIV:
            begin
                work_next.numq = QW'(ma) << FRAC_BITS;
            end
            fpa_pkg::ACT_MIN:
            begin
                work_next.simple = work_next.lt ? a : b;
            end
            fpa_pkg::ACT_MAX:
            begin
                work_next.simple = work_next.lt ? b : a;
            end
            default:
            begin
                work_next.simple = '0;
            end
        endcase

        // Overflow saturates toward the sign of the first operand.
        if (work_next.simple_ovf)
        begin
            work_next.simple = a[DW-1] ? fpa_pkg::WORD_MIN : fpa_pkg::WORD_MAX;
        end
    end

    // Occupancy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    // Item register.
    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            work_reg <= work_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/fpa_div_cell.sv */
// One restoring division cell: develops one quotient bit per item.
`default_nettype none

module fpa_div_cell #(
    parameter int NUM_W = fpa_pkg::DATA_W + fpa_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               up_valid,
    output logic                    up_ready,
    input  wire fpa_pkg::fpa_work_t up,
    output logic                    down_valid,
    input  wire logic               down_ready,
    output fpa_pkg::fpa_work_t      down
);

    localparam int DW = fpa_pkg::DATA_W;

    logic               valid_reg;
    fpa_pkg::fpa_work_t work_reg;
    fpa_pkg::fpa_work_t work_next;

    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;

    assign up_ready   = !valid_reg || down_ready;
    assign down_valid = valid_reg;
    assign down       = work_reg;

    // Shift the next numerator bit into the remainder and try a subtract.
    always_comb
    begin
        trial     = {up.rem, up.numq[NUM_W-1]};
        diff      = trial - {1'b0, up.mb};
        ge        = trial >= {1'b0, up.mb};
        work_next = up;
        if (up.action == fpa_pkg::ACT_DIV)
        begin
            work_next.rem  = ge ? diff[DW-1:0] : trial[DW-1:0];
            work_next.numq = {up.numq[fpa_pkg::QUO_MAX_W-2:0], ge};
        end
    end

    // Occupancy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    // Item register.
    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            work_reg <= work_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/fpa_back.sv */
// Exit stage: rounding, saturation, result select and the output register.
`default_nettype none

module fpa_back #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEFAULT,
    parameter int NUM_W     = fpa_pkg::DATA_W + fpa_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               up_valid,
    output logic                    up_ready,
    input  wire fpa_pkg::fpa_work_t up,
    output logic                    down_valid,
    input  wire logic               down_ready,
    output fpa_pkg::fpa_out_t       down
);

    localparam int DW = fpa_pkg::DATA_W;
    localparam int MW = fpa_pkg::MAG_W;

    logic              valid_reg;
    fpa_pkg::fpa_out_t out_reg;
    fpa_pkg::fpa_out_t out_next;

    logic [2*DW-1:0]   prod;
    logic [MW-1:0]     rounded;
    logic [MW-1:0]     mul_mag;
    logic              round_up;
    logic [MW-1:0]     div_mag;
    fpa_pkg::fpa_sat_t mul_sat;
    fpa_pkg::fpa_sat_t div_sat;
    logic [DW-1:0]     word;
    logic              mb_zero;

    assign up_ready   = !valid_reg || down_ready;
    assign down_valid = valid_reg;
    assign down       = out_reg;

    // Finish the product and the quotient, then pick the action's result.
    always_comb
    begin
        prod     = {up.rem, up.numq[DW-1:0]};
        rounded  = {1'b0, prod} + (MW'(1) << (FRAC_BITS - 1));
        mul_mag  = rounded >> FRAC_BITS;
        round_up = up.rem >= (up.mb - up.rem);
        div_mag  = MW'(up.numq[NUM_W-1:0]) + MW'(round_up);
        mul_sat  = fpa_pkg::fpa_saturate(up.neg, mul_mag);
        div_sat  = fpa_pkg::fpa_saturate(up.neg, div_mag);
        mb_zero  = up.mb == '0;

        out_next.a_less    = up.lt;
        out_next.a_equal   = up.eq;
        out_next.a_greater = !up.lt && !up.eq;
        out_next.status    = fpa_pkg::ST_OK;
        word               = up.simple;

        unique case (up.action)
            fpa_pkg::ACT_ADD,
            fpa_pkg::ACT_SUB:
            begin
                out_next.status = up.simple_ovf ? fpa_pkg::ST_OVF : fpa_pkg::ST_OK;
            end
            fpa_pkg::ACT_MUL:
            begin
                word            = mul_sat.word;
                out_next.status = mul_sat.ovf ? fpa_pkg::ST_OVF : fpa_pkg::ST_OK;
            end
            fpa_pkg::ACT_DIV:
            begin
                if (mb_zero)
                begin
                    // Division by zero saturates by the dividend's sign; a zero dividend gives zero.
                    out_next.status = fpa_pkg::ST_DIVZ;
                    if (up.ma_zero)
                    begin
                        word = '0;
                    end
                    else
                    begin
                        word = up.na ? fpa_pkg::WORD_MIN : fpa_pkg::WORD_MAX;
                    end
                end
                else
                begin
                    word            = div_sat.word;
                    out_next.status = div_sat.ovf ? fpa_pkg::ST_OVF : fpa_pkg::ST_OK;
                end
            end
            default:
            begin
                out_next.status = fpa_pkg::ST_OK;
            end
        endcase

        out_next.result = $signed(word);
    end

    // Occupancy flag of the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/fixed_point_alu_unit.sv */
// Top level of the signed fixed-point ALU: entry stage, division cell row, exit stage.
//
// Signed fixed-point ALU on 32-bit raw words with FRAC_BITS fraction bits. Each word on
// op selects add, subtract, multiply, divide, minimum or maximum and gives one word on res
// with the result, the three comparison flags and a status (overflow saturated or division
// by zero). Multiply and divide are exact and round half away from zero. The unit accepts
// one word per cycle unless res_ready holds it back. Every word passes through one entry
// stage holding the 32x32 multiplier, a row of 32 + FRAC_BITS restoring division cells
// that each develop one quotient bit, and the output register. All actions travel through
// the same row, so results leave in the order the words arrived. Each stage moves on when
// the one after it is empty or moving, so bubbles close up under backpressure.
`default_nettype none

module fixed_point_alu_unit #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              op_valid,
    output logic                   op_ready,
    input  wire fpa_pkg::fpa_in_t  op,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output fpa_pkg::fpa_out_t      res
);

    localparam int NUM_W = fpa_pkg::DATA_W + FRAC_BITS;

    logic               stage_valid [NUM_W+1];
    logic               stage_ready [NUM_W+1];
    fpa_pkg::fpa_work_t stage_work  [NUM_W+1];

    // Operand decode, compare, add, subtract, minimum, maximum and product.
    fpa_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (op_valid),
        .up_ready   (op_ready),
        .up         (op),
        .down_valid (stage_valid[0]),
        .down_ready (stage_ready[0]),
        .down       (stage_work[0])
    );

    // Row of division cells, one quotient bit each.
    for (genvar k = 0; k < NUM_W; k++)
    begin : g_cell
        fpa_div_cell #(
            .NUM_W (NUM_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (stage_valid[k]),
            .up_ready   (stage_ready[k]),
            .up         (stage_work[k]),
            .down_valid (stage_valid[k+1]),
            .down_ready (stage_ready[k+1]),
            .down       (stage_work[k+1])
        );
    end

    // Rounding, saturation and output register.
    fpa_back #(
        .FRAC_BITS (FRAC_BITS),
        .NUM_W     (NUM_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (stage_valid[NUM_W]),
        .up_ready   (stage_ready[NUM_W]),
        .up         (stage_work[NUM_W]),
        .down_valid (res_valid),
        .down_ready (res_ready),
        .down       (res)
    );

    // Exactly one comparison flag is set on every result word.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> $onehot({res.a_less, res.a_equal, res.a_greater}))
        else $error("comparison flags are not one-hot");

    // Only defined status codes leave the unit.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.status == fpa_pkg::ST_OK || res.status == fpa_pkg::ST_OVF
                       || res.status == fpa_pkg::ST_DIVZ))
        else $error("undefined status code");

    // With the output register empty, the whole row can move, so input is open.
    assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> op_ready)
        else $error("input blocked while the output register is empty");

    // No result reaches the output register unless a word has passed the last division cell.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!res_valid && !stage_valid[NUM_W]) |=> !res_valid)
        else $error("result appeared without passing the last cell");

endmodule

`default_nettype wire
